### hw/rtl/meter_mode_e_frame_recognizer_assert.svh
// Assertion macros shared by the frame recogniser RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef METER_MODE_E_FRAME_RECOGNIZER_ASSERT_SVH
`define METER_MODE_E_FRAME_RECOGNIZER_ASSERT_SVH
`ifndef SYNTHESIS
// Checked at every rising edge outside reset.
`define MMEFR_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mmefr assertion failed");
// Checked at every rising edge, reset included.
`define MMEFR_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("mmefr assertion failed");
`else
`define MMEFR_ASSERT(name, clk, rst_n, prop)
`define MMEFR_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

### hw/rtl/mmefr_pkg.sv
// Package of the mode E frame recogniser: character codes, register indexes
// and the classification record handed from the front end to the back end.
// Depends on nothing.
package mmefr_pkg;

  localparam logic [7:0] CH_SOH   = 8'h01;
  localparam logic [7:0] CH_ETX   = 8'h03;
  localparam logic [7:0] CH_ACK   = 8'h06;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUERY = 8'h3F;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_W     = 8'h57;

  localparam logic [7:0] REG_METER_ADDRESS        = 8'd0;
  localparam logic [7:0] REG_METER_ADDRESS_LENGTH = 8'd1;

  typedef enum logic [1:0] {
    KIND_INVALID = 2'd0,
    KIND_REQUEST = 2'd1,
    KIND_ACK     = 2'd2,
    KIND_COMMAND = 2'd3
  } frame_kind_e;

  typedef enum logic [1:0] {
    CMD_PASSWORD = 2'd0,
    CMD_READ     = 2'd1,
    CMD_WRITE    = 2'd2
  } command_code_e;

  // Outcome of the pattern checks for one finished frame.
  typedef struct packed {
    logic       request_ok;
    logic       ack_ok;
    logic       command_ok;
    logic [7:0] letter;
    logic [3:0] digits;   // [2:0] baud code, [3] mode code
  } frame_class_t;

  // Characters of the plain request "/?!" CR LF.
  function automatic logic [7:0] plain_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = CH_SLASH;
      3'd1:    ch = CH_QUERY;
      3'd2:    ch = CH_BANG;
      3'd3:    ch = CH_CR;
      default: ch = CH_LF;
    endcase
    return ch;
  endfunction

endpackage

### hw/rtl/mmefr_front.sv
// Front end of the frame recogniser: configuration registers, per-frame
// state and the running pattern checks. Depends on mmefr_pkg.
module mmefr_front
  import mmefr_pkg::*;
#(
  parameter int ADDRESS_BYTES = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  input  logic [7:0]   cfg_index_i,
  input  logic [63:0]  cfg_data_i,
  input  logic         byte_valid_i,
  input  logic [7:0]   byte_i,
  input  logic         last_i,
  output logic         push_o,
  output frame_class_t class_o
);

  localparam int          AddrWidth = 8 * ADDRESS_BYTES;
  localparam logic [3:0]  AlenMax   = 4'(ADDRESS_BYTES);

  logic [AddrWidth-1:0] addr_q;
  logic [3:0]           alen_cfg_q;
  logic [7:0]           idx_q, xor_q, prev_q, first_q, letter_q;
  logic [2:0]           flags_q, flags_d;
  logic [3:0]           digits_q, digits_d;
  logic [3:0]           alen;
  logic [7:0]           alen8;
  logic [7:0]           addr_byte;
  logic                 plain_ok, addr_ok, ack_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q     <= '0;
      alen_cfg_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_METER_ADDRESS) begin
        addr_q <= cfg_data_i[AddrWidth-1:0];
      end else if (cfg_index_i == REG_METER_ADDRESS_LENGTH) begin
        alen_cfg_q <= cfg_data_i[3:0];
      end
    end
  end

  assign alen  = (alen_cfg_q > AlenMax) ? AlenMax : alen_cfg_q;
  assign alen8 = {4'd0, alen};

  always_comb begin
    addr_byte = '0;
    for (int j = 0; j < ADDRESS_BYTES; j++) begin
      if (idx_q == 8'(j + 2)) begin
        addr_byte = addr_q[j*8 +: 8];
      end
    end
  end

  always_comb begin
    plain_ok = 1'b1;
    if (idx_q < 8'd5) begin
      plain_ok = (byte_i == plain_char(idx_q[2:0]));
    end

    addr_ok = 1'b1;
    if (idx_q == 8'd0) begin
      addr_ok = (byte_i == CH_SLASH);
    end else if (idx_q == 8'd1) begin
      addr_ok = (byte_i == CH_QUERY);
    end else if (idx_q < alen8 + 8'd2) begin
      addr_ok = (byte_i == addr_byte);
    end else if (idx_q == alen8 + 8'd2) begin
      addr_ok = (byte_i == CH_BANG);
    end else if (idx_q == alen8 + 8'd3) begin
      addr_ok = (byte_i == CH_CR);
    end else if (idx_q == alen8 + 8'd4) begin
      addr_ok = (byte_i == CH_LF);
    end

    ack_ok   = 1'b1;
    digits_d = digits_q;
    case (idx_q)
      8'd0: ack_ok = (byte_i == CH_ACK);
      8'd1: ack_ok = (byte_i == CH_ZERO);
      8'd2: begin
        ack_ok = (byte_i >= CH_ZERO) && (byte_i <= CH_SIX);
        if (ack_ok) digits_d[2:0] = byte_i[2:0];
      end
      8'd3: begin
        ack_ok = (byte_i == CH_ZERO) || (byte_i == CH_ONE);
        if (ack_ok) digits_d[3] = byte_i[0];
      end
      8'd4: ack_ok = (byte_i == CH_CR);
      8'd5: ack_ok = (byte_i == CH_LF);
      default: ack_ok = 1'b1;
    endcase

    flags_d = flags_q & {ack_ok, addr_ok, plain_ok};
  end

  // Classification is made on the last word of the frame.
  always_comb begin
    class_o.request_ok = ((idx_q == 8'd4) && flags_d[0]) ||
                         ((idx_q == alen8 + 8'd4) && flags_d[1]);
    class_o.ack_ok     = (idx_q == 8'd5) && flags_d[2];
    class_o.command_ok = (idx_q >= 8'd3) && (first_q == CH_SOH) &&
                         (prev_q == CH_ETX) && (byte_i == xor_q);
    class_o.letter     = letter_q;
    class_o.digits     = digits_d;
  end

  assign push_o = byte_valid_i && last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      xor_q    <= '0;
      prev_q   <= '0;
      first_q  <= '0;
      letter_q <= '0;
      flags_q  <= '1;
      digits_q <= '0;
    end else if (byte_valid_i) begin
      if (last_i) begin
        idx_q    <= '0;
        xor_q    <= '0;
        prev_q   <= '0;
        first_q  <= '0;
        letter_q <= '0;
        flags_q  <= '1;
        digits_q <= '0;
      end else begin
        if (idx_q == 8'd0) first_q <= byte_i;
        if (idx_q == 8'd1) letter_q <= byte_i;
        if (idx_q != 8'd0) xor_q <= xor_q ^ byte_i;
        if (idx_q != 8'hFF) idx_q <= idx_q + 8'd1;
        prev_q   <= byte_i;
        flags_q  <= flags_d;
        digits_q <= digits_d;
      end
    end
  end

endmodule

### hw/rtl/mmefr_queue.sv
// Two-entry queue of frame classifications between front and back end.
// Depends on mmefr_pkg and the assertion macro header.
`include "meter_mode_e_frame_recognizer_assert.svh"
module mmefr_queue
  import mmefr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  frame_class_t push_data_i,
  input  logic         pop_i,
  output logic         full_o,
  output logic         empty_o,
  output frame_class_t pop_data_o
);

  frame_class_t entry_q [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   count_q;

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign pop_data_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  `MMEFR_ASSERT(a_count_range, clk_i, rst_ni, count_q <= 2'd2)
  `MMEFR_ASSERT(a_pop_not_empty, clk_i, rst_ni, pop_i |-> !empty_o)
  `MMEFR_ASSERT(a_ptrs_track_count, clk_i, rst_ni, (wr_ptr_q ^ rd_ptr_q) == count_q[0])
  `MMEFR_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> (count_q == 2'd0))

endmodule

### hw/rtl/mmefr_back.sv
// Back end of the frame recogniser: decodes the command letter and holds the
// result word for the output channel. Depends on mmefr_pkg.
module mmefr_back
  import mmefr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         empty_i,
  input  frame_class_t class_i,
  output logic         pop_o,
  output logic         valid_o,
  input  logic         ready_i,
  output logic [1:0]   frame_kind_o,
  output logic [2:0]   baud_code_o,
  output logic         mode_code_o,
  output logic [1:0]   command_code_o,
  output logic         command_fault_o
);

  logic        valid_q;
  frame_kind_e kind_d, kind_q;
  logic [2:0]  baud_d, baud_q;
  logic        mode_d, mode_q;
  logic [1:0]  cmd_d, cmd_q;
  logic        err_d, err_q;

  always_comb begin
    kind_d = KIND_INVALID;
    baud_d = '0;
    mode_d = 1'b0;
    cmd_d  = CMD_PASSWORD;
    err_d  = 1'b0;
    if (class_i.request_ok) begin
      kind_d = KIND_REQUEST;
    end else if (class_i.ack_ok) begin
      kind_d = KIND_ACK;
      baud_d = class_i.digits[2:0];
      mode_d = class_i.digits[3];
    end else if (class_i.command_ok) begin
      case (class_i.letter)
        CH_P: begin
          kind_d = KIND_COMMAND;
          cmd_d  = CMD_PASSWORD;
        end
        CH_R: begin
          kind_d = KIND_COMMAND;
          cmd_d  = CMD_READ;
        end
        CH_W: begin
          kind_d = KIND_COMMAND;
          cmd_d  = CMD_WRITE;
        end
        default: err_d = 1'b1;
      endcase
    end
  end

  assign pop_o = !empty_i && (!valid_q || ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q <= kind_d;
      baud_q <= baud_d;
      mode_q <= mode_d;
      cmd_q  <= cmd_d;
      err_q  <= err_d;
    end
  end

  assign valid_o         = valid_q;
  assign frame_kind_o    = kind_q;
  assign baud_code_o     = baud_q;
  assign mode_code_o     = mode_q;
  assign command_code_o  = cmd_q;
  assign command_fault_o = err_q;

endmodule

### hw/rtl/meter_mode_e_frame_recognizer.sv
// Top level of the mode E frame recogniser.
// Depends on mmefr_pkg, mmefr_front, mmefr_queue and mmefr_back.
//
// Usage:
// Received bytes enter on the s_axis channel, one word per byte, with tlast
// set on the last byte of each frame. Every frame produces exactly one word
// on the m_axis channel, issued once its last byte has been taken; bytes
// that do not end a frame produce nothing. The result tells whether the
// frame was a request, an option-select acknowledge, a valid command or
// none of these, together with the decoded baud, mode and command codes.
// The configuration channel writes the meter address (index 0) and the
// number of address characters in use (index 1); it is always ready and
// should only be written while no frame is in flight.
// Throughput is one byte per cycle while the queue is not full, set by the
// combinational pattern checks in the front end. A frame's classification
// enters the queue when its last byte is accepted and then moves on to the
// output register that drives m_axis, once that register is free.
// When the receiver stalls, results collect in the two-entry queue and the
// output register; once the queue is full, s_axis_tready drops and no byte
// is taken until a result is drained.
// Reset clears the frame state, the queue and the configuration registers.
module meter_mode_e_frame_recognizer
  import mmefr_pkg::*;
#(
  parameter int ADDRESS_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  // Byte stream in.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tlast,   // frame_end
  // Result stream out.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [2:0] baud_code, [3] mode_code,
                                      // [5:4] command_code, [7:6] zero
  output logic [2:0]  m_axis_tuser    // [1:0] frame_kind, [2] command_fault
);

  frame_class_t front_class, queue_class;
  logic         byte_accept;
  logic         push, pop, queue_full, queue_empty;
  logic [1:0]   frame_kind;
  logic [2:0]   baud_code;
  logic         mode_code;
  logic [1:0]   command_code;
  logic         command_fault;

  // Configuration writes complete in the cycle they are offered.
  assign cfg_ready_o = 1'b1;

  // Bytes are taken whenever the queue can hold another result.
  assign s_axis_tready = !queue_full;
  assign byte_accept   = s_axis_tvalid && s_axis_tready;

  mmefr_front #(
    .ADDRESS_BYTES(ADDRESS_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .byte_valid_i (byte_accept),
    .byte_i       (s_axis_tdata),
    .last_i       (s_axis_tlast),
    .push_o       (push),
    .class_o      (front_class)
  );

  mmefr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_class),
    .pop_i       (pop),
    .full_o      (queue_full),
    .empty_o     (queue_empty),
    .pop_data_o  (queue_class)
  );

  mmefr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (queue_empty),
    .class_i         (queue_class),
    .pop_o           (pop),
    .valid_o         (m_axis_tvalid),
    .ready_i         (m_axis_tready),
    .frame_kind_o    (frame_kind),
    .baud_code_o     (baud_code),
    .mode_code_o     (mode_code),
    .command_code_o  (command_code),
    .command_fault_o (command_fault)
  );

  assign m_axis_tdata = {2'b00, command_code, mode_code, baud_code};
  assign m_axis_tuser = {command_fault, frame_kind};

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the mode E frame recogniser: random and directed frames
// go in on s_axis, a byte-level predictor checks every result word on m_axis.
// Depends on mmefr_pkg and meter_mode_e_frame_recognizer.
module testbench;
  import mmefr_pkg::*;

  localparam int unsigned ADDR_CHARS    = 8;
  localparam int unsigned STUCK_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_WORDS   = 85;
  localparam int unsigned LONG_PAYLOAD  = 300;
  localparam logic [7:0]  CH_BREAK      = 8'h42;
  // No register lives at this index, so a write to it must change nothing.
  localparam logic [7:0]  REG_UNUSED    = 8'hFF;
  localparam logic [7:0]  PLAIN_REQ [5] = '{CH_SLASH, CH_QUERY, CH_BANG, CH_CR, CH_LF};

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } rx_word_t;

  typedef struct {
    frame_kind_e   kind;
    logic [2:0]    baud;
    logic          mode;
    command_code_e cmd;
    logic          command_fault;
  } frame_verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  meter_mode_e_frame_recognizer #(
    .ADDRESS_BYTES(ADDR_CHARS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Stimulus bookkeeping.
  rx_word_t       pending_words[$];
  logic [7:0]     frame_buf[$];
  frame_verdict_t expected_verdicts[$];
  int unsigned    queued_words = 0;
  int unsigned    accepted_words = 0;
  int unsigned    phase_words = 0;
  int unsigned    sender_idle_pct = 0;
  int unsigned    receiver_stall_pct = 0;
  int unsigned    mismatches = 0;
  int unsigned    stuck_cycles = 0;
  logic [63:0]    gen_addr = '0;
  int unsigned    gen_alen = 0;

  // Predictor copy of the registers and of the per-frame state.
  logic [63:0] addr_reg = '0;
  logic [3:0]  addr_len_reg = '0;
  logic [7:0]  frame_pos = '0;
  logic [7:0]  bcc_run = '0;
  logic [7:0]  prev_byte = '0;
  logic [7:0]  head_byte = '0;
  logic [7:0]  letter_byte = '0;
  logic [3:0]  match_flags = '1;
  logic [3:0]  ack_digits = '0;

  // Runs all three pattern checks on one byte; on the last byte of a frame the
  // verdict is queued and the frame state cleared.
  function automatic void classify_rx_byte(input logic [7:0] b, input logic last);
    int unsigned    idx;
    int unsigned    alen;
    int unsigned    len;
    logic           ok;
    frame_verdict_t verdict;
    idx  = frame_pos;
    alen = (addr_len_reg > ADDR_CHARS) ? ADDR_CHARS : addr_len_reg;

    if (idx < 5) begin
      if (b != PLAIN_REQ[idx]) match_flags[0] = 1'b0;
    end

    if (idx == 0) ok = (b == CH_SLASH);
    else if (idx == 1) ok = (b == CH_QUERY);
    else if (idx < alen + 2) ok = (b == addr_reg[8*(idx-2) +: 8]);
    else if (idx == alen + 2) ok = (b == CH_BANG);
    else if (idx == alen + 3) ok = (b == CH_CR);
    else if (idx == alen + 4) ok = (b == CH_LF);
    else ok = 1'b1;
    if (!ok) match_flags[1] = 1'b0;

    case (idx)
      0: ok = (b == CH_ACK);
      1: ok = (b == CH_ZERO);
      2: begin
        ok = (b >= CH_ZERO && b <= CH_SIX);
        if (ok) ack_digits[2:0] = 3'(b - CH_ZERO);
      end
      3: begin
        ok = (b == CH_ZERO || b == CH_ONE);
        if (ok) ack_digits[3] = b[0];
      end
      4: ok = (b == CH_CR);
      5: ok = (b == CH_LF);
      default: ok = 1'b1;
    endcase
    if (!ok) match_flags[2] = 1'b0;

    if (idx == 0) head_byte = b;
    else if (idx == 1) letter_byte = b;

    if (!last) begin
      if (idx >= 1) bcc_run ^= b;
      prev_byte = b;
      if (frame_pos != 8'd255) frame_pos++;
      return;
    end

    verdict = '{kind: KIND_INVALID, baud: 3'd0, mode: 1'b0, cmd: CMD_PASSWORD,
                command_fault: 1'b0};
    // A saturated position makes every long frame look 256 bytes long.
    len = idx + 1;
    if ((len == 5 && match_flags[0]) || (len == alen + 5 && match_flags[1])) begin
      verdict.kind = KIND_REQUEST;
    end else if (len == 6 && match_flags[2]) begin
      verdict.kind = KIND_ACK;
      verdict.baud = ack_digits[2:0];
      verdict.mode = ack_digits[3];
    end else if (len >= 4 && head_byte == CH_SOH && prev_byte == CH_ETX && b == bcc_run) begin
      verdict.kind = KIND_COMMAND;
      case (letter_byte)
        CH_P: verdict.cmd = CMD_PASSWORD;
        CH_R: verdict.cmd = CMD_READ;
        CH_W: verdict.cmd = CMD_WRITE;
        default: begin
          // Break and unknown letters are flagged, not classified.
          verdict.kind          = KIND_INVALID;
          verdict.command_fault = 1'b1;
        end
      endcase
    end
    expected_verdicts.push_back(verdict);

    frame_pos   = '0;
    bcc_run     = '0;
    prev_byte   = '0;
    head_byte   = '0;
    letter_byte = '0;
    match_flags = '1;
    ack_digits  = '0;
  endfunction

  function automatic void check_field(input string field, input logic [2:0] want,
                                      input logic [2:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  // Byte driver: presents the next pending word once the current one is taken.
  always @(posedge clk_i or negedge rst_ni) begin : byte_driver
    rx_word_t word;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        word = pending_words.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word.data;
        s_axis_tlast  <= word.last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Tracks register writes and accepted bytes, and checks every result word
  // against the oldest outstanding verdict.
  always @(posedge clk_i) begin : scoreboard
    frame_verdict_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_METER_ADDRESS:        addr_reg = cfg_data_i;
          REG_METER_ADDRESS_LENGTH: addr_len_reg = cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        classify_rx_byte(s_axis_tdata, s_axis_tlast);
        accepted_words++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_verdicts.size() == 0) begin
          $error("result word with no frame outstanding");
          mismatches++;
        end else begin
          want = expected_verdicts.pop_front();
          check_field("frame_kind", 3'(want.kind), 3'(m_axis_tuser[1:0]));
          check_field("baud_code", want.baud, m_axis_tdata[2:0]);
          check_field("mode_code", 3'(want.mode), 3'(m_axis_tdata[3]));
          check_field("command_code", 3'(want.cmd), 3'(m_axis_tdata[5:4]));
          check_field("command_fault", 3'(want.command_fault), 3'(m_axis_tuser[2]));
        end
      end
    end
  end

  // Ends the run if nothing moves on any channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic write_reg(input logic [7:0] index, input logic [63:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Waits until every queued byte is taken and every verdict has been matched.
  task automatic drain_stream();
    while (accepted_words != queued_words || expected_verdicts.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic flush_frame();
    foreach (frame_buf[i]) begin
      pending_words.push_back('{data: frame_buf[i], last: (i == frame_buf.size() - 1)});
    end
    queued_words += frame_buf.size();
    phase_words  += frame_buf.size();
    frame_buf.delete();
  endtask

  task automatic build_plain();
    foreach (PLAIN_REQ[i]) frame_buf.push_back(PLAIN_REQ[i]);
  endtask

  task automatic build_ack(input logic [7:0] baud_ch, input logic [7:0] mode_ch);
    frame_buf.push_back(CH_ACK);
    frame_buf.push_back(CH_ZERO);
    frame_buf.push_back(baud_ch);
    frame_buf.push_back(mode_ch);
    frame_buf.push_back(CH_CR);
    frame_buf.push_back(CH_LF);
  endtask

  task automatic build_command(input logic [7:0] letter, input int unsigned payload);
    logic [7:0] bcc;
    frame_buf.push_back(CH_SOH);
    frame_buf.push_back(letter);
    repeat (payload) frame_buf.push_back(8'($urandom));
    frame_buf.push_back(CH_ETX);
    bcc = '0;
    for (int i = 1; i < frame_buf.size(); i++) bcc ^= frame_buf[i];
    frame_buf.push_back(bcc);
  endtask

  // Mostly well-formed frames with random content; the rest is short
  // commands, noise and frames broken by one edit.
  task automatic build_random_frame();
    int unsigned pick;
    logic [7:0]  letter;
    pick = $urandom_range(99);
    if (pick < 15) begin
      build_plain();
    end else if (pick < 35) begin
      frame_buf.push_back(CH_SLASH);
      frame_buf.push_back(CH_QUERY);
      for (int i = 0; i < gen_alen; i++) frame_buf.push_back(gen_addr[8*i +: 8]);
      frame_buf.push_back(CH_BANG);
      frame_buf.push_back(CH_CR);
      frame_buf.push_back(CH_LF);
    end else if (pick < 55) begin
      // A baud digit of '7' is just out of range.
      build_ack(CH_ZERO + 8'($urandom_range(7)), CH_ZERO + 8'($urandom_range(1)));
    end else if (pick < 85) begin
      case ($urandom_range(9))
        0, 1:    letter = CH_P;
        2, 3:    letter = CH_R;
        4, 5:    letter = CH_W;
        6:       letter = CH_BREAK;
        default: letter = 8'($urandom);
      endcase
      build_command(letter, $urandom_range(8));
    end else if (pick < 90) begin
      frame_buf.push_back(CH_SOH);
      if ($urandom_range(2) != 0) frame_buf.push_back(CH_ETX);
      if ($urandom_range(1) != 0) frame_buf.push_back(CH_ETX);
    end else begin
      repeat ($urandom_range(1, 12)) frame_buf.push_back(8'($urandom));
    end

    if ($urandom_range(99) < 15) begin
      case ($urandom_range(2))
        0: frame_buf[$urandom_range(frame_buf.size() - 1)] = 8'($urandom);
        1: if (frame_buf.size() > 1) void'(frame_buf.pop_back());
        default: frame_buf.push_back(8'($urandom));
      endcase
    end
  endtask

  initial begin
    int unsigned len_code;
    logic [63:0] value;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames under the reset configuration, where the empty address
    // makes the addressed request the plain one.
    build_plain();
    flush_frame();
    build_ack(CH_SIX, CH_ONE);
    flush_frame();
    build_command(CH_W, 0);
    flush_frame();
    // A command frame one byte too short: right structure and BCC, yet it is
    // classed as invalid without a command fault.
    frame_buf = '{CH_SOH, CH_ETX, CH_ETX};
    flush_frame();
    frame_buf = '{8'hFF};
    flush_frame();
    frame_buf = '{8'h00};
    flush_frame();
    build_command(CH_BREAK, 0);
    flush_frame();
    drain_stream();

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 68; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 68; end
        default: begin sender_idle_pct = 15; receiver_stall_pct = 15; end
      endcase

      case (phase)
        0: gen_addr = '1;
        1: gen_addr = '0;
        3, 5: for (int i = 0; i < 8; i++) gen_addr[8*i +: 8] = CH_ZERO + 8'($urandom_range(9));
        default: gen_addr = {$urandom, $urandom};
      endcase
      // Lengths above the address width must behave as the full width.
      case (phase)
        0: len_code = 0;
        1: len_code = 8;
        2: len_code = 15;
        3: len_code = 1;
        4: len_code = 5;
        5: len_code = 9;
        6: len_code = 3;
        default: len_code = $urandom_range(15);
      endcase
      gen_alen = (len_code > ADDR_CHARS) ? ADDR_CHARS : len_code;

      write_reg(REG_METER_ADDRESS, gen_addr);
      value = {$urandom, $urandom};
      value[3:0] = 4'(len_code);
      write_reg(REG_METER_ADDRESS_LENGTH, value);
      if (phase == 4) write_reg(REG_UNUSED, {$urandom, $urandom});

      phase_words = 0;
      if (phase == 2) begin
        // Long enough for the byte position to saturate.
        build_command(CH_R, LONG_PAYLOAD);
        flush_frame();
      end
      while (phase_words < PHASE_WORDS) begin
        build_random_frame();
        flush_frame();
      end
      drain_stream();
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
